// ===== hdl/dq_pkg.sv =====
// shared types and constants of the double-ended queue
`timescale 1ns / 1ps

package dq_pkg;

  localparam int DEPTH_DEF = 16;
  localparam int WORD_W    = 32;
  localparam int COUNT_W   = 5;

  typedef enum logic [1:0] {
    OP_PUSH_FRONT = 2'd0,
    OP_POP_FRONT  = 2'd1,
    OP_PUSH_BACK  = 2'd2,
    OP_POP_BACK   = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_FULL  = 2'd2
  } status_t;

  // per-item result control that travels beside the memory read
  typedef struct packed {
    logic                pop_ok;
    status_t             status;
    logic [COUNT_W-1:0]  count;
  } meta_t;

endpackage

// ===== hdl/dq_ifs.sv =====
// valid/ready channel interfaces for requests and results
`timescale 1ns / 1ps

interface dq_req_if;
  logic                                 valid;
  logic                                 ready;
  logic [1:0]                           op;
  logic signed [dq_pkg::WORD_W-1:0]     value_in;

  modport source (output valid, output op, output value_in, input ready);
  modport sink   (input valid, input op, input value_in, output ready);
endinterface

interface dq_rsp_if;
  logic                                 valid;
  logic                                 ready;
  logic signed [dq_pkg::WORD_W-1:0]     value_out;
  logic [1:0]                           status;
  logic [dq_pkg::COUNT_W-1:0]           count_out;

  modport source (output valid, output value_out, output status, output count_out,
                  input ready);
  modport sink   (input valid, input value_out, input status, input count_out,
                  output ready);
endinterface

// ===== hdl/double_ended_queue_top.sv =====
// top level of the bounded double-ended queue
`timescale 1ns / 1ps

// bounded double-ended queue of DEPTH signed 32-bit words in a circular buffer.
// each request transfer (op: push front, pop front, push back, pop back)
// yields exactly one result transfer with the popped word (zero for pushes and
// failed pops), a status (ok, pop on empty, push on full) and the element count
// after the request, taken modulo 32. the words live in a single-port
// synchronous ram; the front index and count sit in flip-flops. on a request
// transfer, pushes write the ram and pops issue the ram read; the word is
// registered in the ram read register and moves into the result register
// when stage one advances, so a result passes through stage one and the
// result register before it is presented. the block takes one request every
// cycle while results are drained. a push followed at once
// by a pop of the same slot is safe because the write lands at the earlier edge.
// a result left waiting in the output register does not stop the next request;
// a second waiting result does. no request is taken during reset. ram contents
// are not cleared at reset: only slots written by a push are ever read.

module double_ended_queue_top #(
  parameter int DEPTH = dq_pkg::DEPTH_DEF
) (
  input  logic  clk,
  input  logic  rst_n,
  dq_req_if.sink   in_chan,
  dq_rsp_if.source out_chan
);

  localparam int AW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);

  // handshake of the request side
  logic in_acc;
  logic s1_adv;

  // ram request from the pointer logic
  logic                        mem_we, mem_re;
  logic [AW-1:0]               mem_addr;
  logic [dq_pkg::WORD_W-1:0]   mem_wdata, mem_rdata;
  dq_pkg::meta_t               meta;

  // stage one: ram read in flight
  logic          s1_valid_r, s1_valid_nxt;
  dq_pkg::meta_t s1_meta_r;

  // result register
  logic                        out_valid_r, out_valid_nxt;
  logic [dq_pkg::WORD_W-1:0]   out_value_r;
  dq_pkg::status_t             out_status_r;
  logic [dq_pkg::COUNT_W-1:0]  out_count_r;

  // stage one moves on whenever the result register is free or being emptied
  assign s1_adv         = !out_valid_r || out_chan.ready;
  assign in_chan.ready  = rst_n && (!s1_valid_r || s1_adv);
  assign in_acc         = in_chan.valid && in_chan.ready;

  dq_ctrl #(
    .DEPTH (DEPTH),
    .AW    (AW),
    .CW    (CW)
  ) u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .accept    (in_acc),
    .op        (dq_pkg::op_t'(in_chan.op)),
    .value_in  (in_chan.value_in),
    .mem_we    (mem_we),
    .mem_re    (mem_re),
    .mem_addr  (mem_addr),
    .mem_wdata (mem_wdata),
    .meta      (meta)
  );

  dq_mem #(
    .DEPTH (DEPTH),
    .AW    (AW)
  ) u_mem (
    .clk   (clk),
    .we    (mem_we),
    .re    (mem_re),
    .addr  (mem_addr),
    .wdata (mem_wdata),
    .rdata (mem_rdata)
  );

  // stage one valid: set by a request transfer, cleared once it moves on
  always_comb begin
    if (in_acc) begin
      s1_valid_nxt = 1'b1;
    end else if (s1_adv) begin
      s1_valid_nxt = 1'b0;
    end else begin
      s1_valid_nxt = s1_valid_r;
    end
  end

  always_comb begin
    if (s1_valid_r && s1_adv) begin
      out_valid_nxt = 1'b1;
    end else if (out_chan.ready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // payload registers, no reset needed
  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_meta_r <= meta;
    end
    if (s1_valid_r && s1_adv) begin
      out_value_r  <= s1_meta_r.pop_ok ? mem_rdata : '0;
      out_status_r <= s1_meta_r.status;
      out_count_r  <= s1_meta_r.count;
    end
  end

  assign out_chan.valid     = out_valid_r;
  assign out_chan.value_out = out_value_r;
  assign out_chan.status    = out_status_r;
  assign out_chan.count_out = out_count_r;

  // a request transfer always finds stage one free or moving on
  a_no_overrun: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc |-> (!s1_valid_r || s1_adv))
    else $error("request taken over a stalled ram read");

  // every request transfer occupies stage one on the next cycle
  a_s1_follows: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc |=> s1_valid_r)
    else $error("request transfer lost before stage one");

  // failed operations return a zero word
  a_zero_word: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && (out_status_r == dq_pkg::ST_EMPTY || out_status_r == dq_pkg::ST_FULL))
      |-> (out_value_r == '0))
    else $error("non-zero word on a failed operation");

  // a waiting result holds until transferred
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_chan.ready) |=> (out_valid_r && $stable(out_value_r)))
    else $error("waiting result changed");

endmodule

// ===== hdl/dq_mem.sv =====
// entry store: single-port synchronous ram with registered read data
`timescale 1ns / 1ps

module dq_mem #(
  parameter int DEPTH = dq_pkg::DEPTH_DEF,
  parameter int AW    = $clog2(DEPTH)
) (
  input  logic                          clk,
  input  logic                          we,
  input  logic                          re,
  input  logic [AW-1:0]                 addr,
  input  logic [dq_pkg::WORD_W-1:0]     wdata,
  output logic [dq_pkg::WORD_W-1:0]     rdata
);

  logic [dq_pkg::WORD_W-1:0] mem [DEPTH];
  logic [dq_pkg::WORD_W-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata_r <= mem[addr];
    end
  end

  assign rdata = rdata_r;

endmodule

// ===== hdl/dq_ctrl.sv =====
// front index and element count, status decision and ram addressing
`timescale 1ns / 1ps

module dq_ctrl #(
  parameter int DEPTH = dq_pkg::DEPTH_DEF,
  parameter int AW    = $clog2(DEPTH),
  parameter int CW    = $clog2(DEPTH + 1)
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          accept,
  input  dq_pkg::op_t                   op,
  input  logic [dq_pkg::WORD_W-1:0]     value_in,
  output logic                          mem_we,
  output logic                          mem_re,
  output logic [AW-1:0]                 mem_addr,
  output logic [dq_pkg::WORD_W-1:0]     mem_wdata,
  output dq_pkg::meta_t                 meta
);

  localparam int SW = CW + 1;
  localparam int OW = dq_pkg::COUNT_W;
  localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);
  localparam logic [AW-1:0] LAST_IDX = AW'(DEPTH - 1);
  localparam logic [SW-1:0] DEPTH_S  = SW'(DEPTH);

  logic [AW-1:0] front_r, front_nxt;
  logic [CW-1:0] count_r, count_nxt;

  logic          full, empty, is_pop;
  logic [AW-1:0] front_dec, front_inc, back_addr;
  logic [CW-1:0] offs;
  logic [SW-1:0] sum, wrapped;

  assign full   = (count_r == FULL_CNT);
  assign empty  = (count_r == '0);
  assign is_pop = (op == dq_pkg::OP_POP_FRONT) || (op == dq_pkg::OP_POP_BACK);

  assign front_dec = (front_r == '0) ? LAST_IDX : front_r - AW'(1);
  assign front_inc = (front_r == LAST_IDX) ? '0 : front_r + AW'(1);

  // back slot: front + count for a push, front + count - 1 for a pop
  assign offs    = is_pop ? count_r - CW'(1) : count_r;
  assign sum     = SW'(front_r) + SW'(offs);
  assign wrapped = (sum >= DEPTH_S) ? sum - DEPTH_S : sum;
  assign back_addr = wrapped[AW-1:0];

  always_comb begin
    front_nxt   = front_r;
    count_nxt   = count_r;
    mem_we      = 1'b0;
    mem_re      = 1'b0;
    mem_addr    = front_r;
    meta.pop_ok = 1'b0;
    meta.status = dq_pkg::ST_OK;
    unique case (op)
      dq_pkg::OP_PUSH_FRONT: begin
        mem_addr = front_dec;
        if (full) begin
          meta.status = dq_pkg::ST_FULL;
        end else begin
          mem_we    = accept;
          front_nxt = front_dec;
          count_nxt = count_r + CW'(1);
        end
      end
      dq_pkg::OP_PUSH_BACK: begin
        mem_addr = back_addr;
        if (full) begin
          meta.status = dq_pkg::ST_FULL;
        end else begin
          mem_we    = accept;
          count_nxt = count_r + CW'(1);
        end
      end
      dq_pkg::OP_POP_FRONT: begin
        mem_addr = front_r;
        if (empty) begin
          meta.status = dq_pkg::ST_EMPTY;
        end else begin
          mem_re      = accept;
          meta.pop_ok = 1'b1;
          front_nxt   = front_inc;
          count_nxt   = count_r - CW'(1);
        end
      end
      dq_pkg::OP_POP_BACK: begin
        mem_addr = back_addr;
        if (empty) begin
          meta.status = dq_pkg::ST_EMPTY;
        end else begin
          mem_re      = accept;
          meta.pop_ok = 1'b1;
          count_nxt   = count_r - CW'(1);
        end
      end
      default: begin
        mem_addr = front_r;
      end
    endcase
    // count field is the low bits of the element count
    meta.count = OW'(count_nxt);
  end

  assign mem_wdata  = value_in;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      front_r <= '0;
      count_r <= '0;
    end else if (accept) begin
      front_r <= front_nxt;
      count_r <= count_nxt;
    end
  end

endmodule

// ===== verif/tb_double_ended_queue_top.sv =====
// self-checking testbench for the bounded double-ended queue
`timescale 1ns / 1ps

module tb_double_ended_queue_top;

  localparam int DEPTH       = dq_pkg::DEPTH_DEF;
  localparam int HOLD_CYCLES = 80;       // long result back-pressure stretch
  localparam int TAIL_CYCLES = 8;        // idle tail at the end of the run
  localparam int BURST_LEN   = 26;

  // one request as queued for the driver
  typedef struct {
    dq_pkg::op_t                       op;
    logic signed [dq_pkg::WORD_W-1:0]  word;
  } deque_req_t;

  // one result as the queue should return it
  typedef struct {
    logic signed [dq_pkg::WORD_W-1:0]  word;
    dq_pkg::status_t                   status;
    logic [dq_pkg::COUNT_W-1:0]        count;
  } deque_result_t;

  logic clk;
  logic rst_n;

  dq_req_if req_if ();
  dq_rsp_if rsp_if ();

  double_ended_queue_top #(.DEPTH(DEPTH)) dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (req_if),
    .out_chan (rsp_if)
  );

  // requests waiting for the driver, results waiting for the monitor
  deque_req_t    send_q[$];
  deque_result_t pending_results[$];
  deque_req_t    cur_req;

  // mirror of the queue contents, kept in step with accepted requests
  logic signed [dq_pkg::WORD_W-1:0] model_slots [DEPTH];
  int model_front = 0;
  int model_count = 0;

  // idling knobs, changed per phase by the stimulus process
  int  send_idle_pct;
  int  recv_stall_pct;
  bit  hold_go;
  bit  rx_hold;

  // bookkeeping for the summary
  int  error_count  = 0;
  int  reqs_sent    = 0;
  int  results_seen = 0;
  int  n_pop_ok     = 0;
  int  n_empty      = 0;
  int  n_full       = 0;
  int  peak_count   = 0;

  // clock: 10 ns period
  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  // apply one request to the mirror and return what the block should answer
  function automatic deque_result_t deque_apply(dq_pkg::op_t op,
                                                logic signed [dq_pkg::WORD_W-1:0] word);
    deque_result_t r;
    r.word   = '0;
    r.status = dq_pkg::ST_OK;
    if (op == dq_pkg::OP_PUSH_FRONT || op == dq_pkg::OP_PUSH_BACK) begin
      if (model_count >= DEPTH) begin
        // full: word is dropped, nothing moves
        r.status = dq_pkg::ST_FULL;
      end else if (op == dq_pkg::OP_PUSH_FRONT) begin
        model_front = (model_front + DEPTH - 1) % DEPTH;
        model_slots[model_front] = word;
        model_count++;
      end else begin
        model_slots[(model_front + model_count) % DEPTH] = word;
        model_count++;
      end
    end else if (model_count == 0) begin
      // empty: nothing to hand back
      r.status = dq_pkg::ST_EMPTY;
    end else if (op == dq_pkg::OP_POP_FRONT) begin
      r.word = model_slots[model_front];
      model_front = (model_front + 1) % DEPTH;
      model_count--;
      n_pop_ok++;
    end else begin
      // back element sits count-1 slots after the front
      r.word = model_slots[(model_front + model_count - 1) % DEPTH];
      model_count--;
      n_pop_ok++;
    end
    r.count = dq_pkg::COUNT_W'(model_count);
    return r;
  endfunction

  task automatic queue_req(dq_pkg::op_t op, logic signed [dq_pkg::WORD_W-1:0] word);
    deque_req_t q;
    q.op   = op;
    q.word = word;
    send_q.push_back(q);
  endtask

  // random burst: push bias picked per burst so the fill level swings
  // between empty and full, with the odd extreme data word
  task automatic queue_burst(int n);
    int push_pct;
    int pick;
    logic signed [dq_pkg::WORD_W-1:0] w;
    bit front;
    pick = int'($urandom_range(2));
    push_pct = (pick == 0) ? 15 : (pick == 1) ? 50 : 85;
    for (int i = 0; i < n; i++) begin
      front = 1'($urandom_range(1));
      case ($urandom_range(7))
        0:       w = 32'sh8000_0000;
        1:       w = 32'sh7fff_ffff;
        2:       w = '0;
        3:       w = '1;
        default: w = $urandom;
      endcase
      if ($urandom_range(99) < push_pct) begin
        queue_req(front ? dq_pkg::OP_PUSH_FRONT : dq_pkg::OP_PUSH_BACK, w);
      end else begin
        queue_req(front ? dq_pkg::OP_POP_FRONT : dq_pkg::OP_POP_BACK, w);
      end
    end
  endtask

  // sender pause: hold back until every queued request has gone and
  // every expected result has come home
  task automatic wait_drained();
    while (send_q.size() != 0 || req_if.valid || pending_results.size() != 0)
      @(negedge clk);
  endtask

  // request driver: presents queued requests, holds each until its transfer,
  // and feeds the mirror at the edge the transfer happens
  always @(posedge clk) begin
    if (!rst_n) begin
      req_if.valid    <= 1'b0;
      req_if.op       <= dq_pkg::OP_PUSH_FRONT;
      req_if.value_in <= '0;
    end else begin
      if (req_if.valid && req_if.ready) begin
        pending_results.push_back(deque_apply(cur_req.op, cur_req.word));
        reqs_sent++;
      end
      // free to move on when idle or the current request was just taken
      if (!req_if.valid || req_if.ready) begin
        if (send_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          cur_req         = send_q.pop_front();
          req_if.valid    <= 1'b1;
          req_if.op       <= cur_req.op;
          req_if.value_in <= cur_req.word;
        end else begin
          req_if.valid <= 1'b0;
        end
      end
    end
  end

  // result monitor: checks every result transfer against the oldest
  // expectation and throttles ready
  always @(posedge clk) begin
    deque_result_t exp_res;
    if (!rst_n) begin
      rsp_if.ready <= 1'b0;
    end else begin
      if (rsp_if.valid && rsp_if.ready) begin
        results_seen++;
        if (pending_results.size() == 0) begin
          error_count++;
          $display("%0t: unexpected result value=%0d status=%0d count=%0d", $realtime,
                   rsp_if.value_out, rsp_if.status, rsp_if.count_out);
        end else begin
          exp_res = pending_results.pop_front();
          if (rsp_if.value_out !== exp_res.word) begin
            error_count++;
            $display("%0t: value_out expected %0d got %0d", $realtime,
                     exp_res.word, rsp_if.value_out);
          end
          if (rsp_if.status !== exp_res.status) begin
            error_count++;
            $display("%0t: status expected %0d got %0d", $realtime,
                     exp_res.status, rsp_if.status);
          end
          if (rsp_if.count_out !== exp_res.count) begin
            error_count++;
            $display("%0t: count_out expected %0d got %0d", $realtime,
                     exp_res.count, rsp_if.count_out);
          end
          case (exp_res.status)
            dq_pkg::ST_EMPTY: n_empty++;
            dq_pkg::ST_FULL:  n_full++;
            default: ;
          endcase
          if (int'(exp_res.count) > peak_count)
            peak_count = int'(exp_res.count);
        end
      end
      rsp_if.ready <= !rx_hold && ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // long receiver hold-off, counted here on the falling edge so the
  // monitor sees a settled flag
  initial begin
    rx_hold = 1'b0;
    wait (hold_go);
    rx_hold = 1'b1;
    repeat (HOLD_CYCLES) @(negedge clk);
    rx_hold = 1'b0;
  end

  // stimulus and end of run
  initial begin
    rst_n           = 1'b0;
    send_idle_pct   = 0;
    recv_stall_pct  = 0;
    hold_go         = 1'b0;

    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // directed: pops on an empty queue at both ends
    queue_req(dq_pkg::OP_POP_FRONT, 32'sh1234_5678);
    queue_req(dq_pkg::OP_POP_BACK, '1);
    // extreme words in at both ends, then out again; the second pop
    // takes the last element and leaves both ends empty
    queue_req(dq_pkg::OP_PUSH_FRONT, 32'sh7fff_ffff);
    queue_req(dq_pkg::OP_PUSH_BACK, 32'sh8000_0000);
    queue_req(dq_pkg::OP_POP_FRONT, '0);
    queue_req(dq_pkg::OP_POP_BACK, '0);
    queue_req(dq_pkg::OP_POP_BACK, '0);
    // fill to the brim from both ends, with front wrap-around
    for (int i = 0; i < DEPTH; i++) begin
      queue_req((i % 2) ? dq_pkg::OP_PUSH_BACK : dq_pkg::OP_PUSH_FRONT,
                (i == 0) ? '1 : (i == 1) ? '0 : $urandom);
    end
    // pushes on a full queue at both ends are refused
    queue_req(dq_pkg::OP_PUSH_FRONT, 32'sh7fff_ffff);
    queue_req(dq_pkg::OP_PUSH_BACK, 32'sh8000_0000);
    wait_drained();

    // back-pressure: receiver holds off while the sender keeps offering,
    // so the result path backs up and the request side stalls
    queue_burst(30);
    hold_go = 1'b1;
    wait_drained();

    // random phases with differing idle patterns
    for (int phase = 0; phase < 4; phase++) begin
      case (phase)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 66; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 66; end
        default: begin send_idle_pct = 15; recv_stall_pct = 15; end
      endcase
      for (int b = 0; b < 5; b++) begin
        queue_burst(BURST_LEN);
        // once per phase, after the third burst, let everything settle
        if (b == 2) wait_drained();
      end
      wait_drained();
    end

    // every request has its transfer; wait out results and a short tail
    wait_drained();
    repeat (TAIL_CYCLES) @(negedge clk);

    $display("run covered %0d requests, %0d results: %0d good pops, %0d empty pops,",
             reqs_sent, results_seen, n_pop_ok, n_empty);
    $display("%0d refused pushes, peak fill %0d of %0d, %0d errors",
             n_full, peak_count, DEPTH, error_count);
    if (error_count == 0 && pending_results.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

  // watchdog: far beyond the slowest correct run
  initial begin
    #2_000_000;
    $display("Some tests failed");
    $finish;
  end

endmodule

// ===== sim.f =====
hdl/dq_pkg.sv
hdl/dq_ifs.sv
hdl/dq_mem.sv
hdl/dq_ctrl.sv
hdl/double_ended_queue_top.sv
verif/tb_double_ended_queue_top.sv
